>>> rtl/utf8_to_utf32_decoder_core_defines.svh
// ----------------------------------------------------------------------------
// UTF-8 decoder assertion macros
// Shared property shapes clocked on aclk and disabled while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef UTF8_TO_UTF32_DECODER_CORE_DEFINES_SVH
`define UTF8_TO_UTF32_DECODER_CORE_DEFINES_SVH

// same-cycle implication
`define UTF8D_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define UTF8D_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/utf8d_pkg.sv
// ----------------------------------------------------------------------------
// UTF-8 decoder package
// Request and result types, queue sizing and the lead byte mask.
// ----------------------------------------------------------------------------
`default_nettype none

package utf8d_pkg;

    localparam int CNT_W = 24;
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    localparam int RQ_DEPTH = 4;
    localparam int RQ_AW = $clog2(RQ_DEPTH);
    localparam int RQ_CW = $clog2(RQ_DEPTH + 1);

    typedef struct packed {
        logic [7:0] byte_in;
        logic       string_end;
    } in_t;

    typedef struct packed {
        logic [31:0]      code_point;
        logic [1:0]       utf16_units;
        logic [CNT_W-1:0] points_so_far;
        logic [CNT_W-1:0] units_so_far;
        logic             last_point;
    } out_t;

    typedef struct packed {
        logic [1:0] cnt;
        out_t       first;
        out_t       second;
    } push_t;

    function automatic logic [31:0] lead_value(input logic [7:0] b);
        logic [31:0] v;
        v = 32'd0;
        if (!b[7]) begin
            v = {25'd0, b[6:0]};
        end else if (!b[6]) begin
            v = {26'd0, b[5:0]};
        end else if (!b[5]) begin
            v = {27'd0, b[4:0]};
        end else if (!b[4]) begin
            v = {28'd0, b[3:0]};
        end else if (!b[3]) begin
            v = {29'd0, b[2:0]};
        end else if (!b[2]) begin
            v = {30'd0, b[1:0]};
        end else if (!b[1]) begin
            v = {31'd0, b[0]};
        end
        return v;
    endfunction

endpackage

`default_nettype wire

>>> rtl/utf8_to_utf32_decoder_core.sv
// ----------------------------------------------------------------------------
// UTF-8 to UTF-32 decoder core
// Streaming byte-in, code-point-out decoder without validation.
//
// s_ channel: one byte of a string per request, string_end marks its last byte.
// m_ channel: decoded code points with UTF-16 unit size and running totals.
// A code point leaves once the next non-continuation byte or the string end
// is seen, so one byte releases zero, one or two results.
// A byte is registered at acceptance, decoded from that register once the queue
// has room for two results, and its results are queued and offered on m_ from there.
// Throughput: one byte per cycle while the queue has room; a byte that releases
// two results needs two transfers on the output port, absorbed by a four-entry
// result queue. Input is held off while the queue has fewer than two free entries.
// Reset clears the pending code point, the totals and the queue.
// When m_ready stays low the queue fills, then s_ready drops; nothing is lost.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_to_utf32_decoder_core import utf8d_pkg::*; (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_valid,
    output logic      s_ready,
    input  wire in_t  s_data,
    output logic      m_valid,
    input  wire logic m_ready,
    output out_t      m_data
);

`include "utf8_to_utf32_decoder_core_defines.svh"

    logic  in_valid_reg, in_valid_next;
    in_t   in_data_reg;
    logic  proc_fire;
    logic  room_two;
    logic  pend_busy;
    push_t push;

    assign proc_fire     = in_valid_reg && room_two;
    assign s_ready       = !in_valid_reg || proc_fire;
    assign in_valid_next = (s_valid && s_ready) || (in_valid_reg && !proc_fire);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
    end

    utf8d_step u_step (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .fire      (proc_fire),
        .in_data   (in_data_reg),
        .push      (push),
        .pend_busy (pend_busy)
    );

    utf8d_result_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .pop       (m_valid && m_ready),
        .head      (m_data),
        .not_empty (m_valid),
        .room_two  (room_two)
    );

    `UTF8D_ASSERT_NEXT(a_hold_in, in_valid_reg && !proc_fire, in_valid_reg && $stable(in_data_reg), "input request dropped while queue full")
    `UTF8D_ASSERT_IMPLY(a_pair_order, push.cnt == 2'd2, !push.first.last_point && push.second.last_point, "bad last_point order in result pair")
    `UTF8D_ASSERT_NEXT(a_end_clears, proc_fire && in_data_reg.string_end, !pend_busy, "code point still pending after string end")
    `UTF8D_ASSERT_IMPLY(a_units_range, m_valid, m_data.utf16_units == 2'd1 || m_data.utf16_units == 2'd2, "utf16_units out of range")

endmodule

`default_nettype wire

>>> rtl/utf8d_step.sv
// ----------------------------------------------------------------------------
// UTF-8 decoder step
// Holds the pending code point and the running totals, and forms the zero,
// one or two results that one byte releases.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8d_step import utf8d_pkg::*; (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic fire,
    input  wire in_t  in_data,
    output push_t     push,
    output logic      pend_busy
);

    logic             pv_reg, pv_next;
    logic [31:0]      pp_reg, pp_next;
    logic [CNT_W-1:0] pc_reg, pc_next;
    logic [CNT_W-1:0] uc_reg, uc_next;

    logic             cont;
    logic             flush;
    logic [31:0]      new_pt;
    logic [31:0]      first_pt;
    logic [1:0]       units_a;
    logic [1:0]       units_b;
    logic [CNT_W+1:0] pc_sum1, pc_sum2;
    logic [CNT_W+1:0] uc_sum1, uc_sum2;
    logic [CNT_W-1:0] pc1, pc2, uc1, uc2;

    function automatic logic [CNT_W-1:0] sat_cnt(input logic [CNT_W+1:0] s);
        return (s > {2'b00, CNT_MAX}) ? CNT_MAX : s[CNT_W-1:0];
    endfunction

    always_comb begin
        cont     = (in_data.byte_in[7:6] == 2'b10) && pv_reg;
        new_pt   = cont ? {pp_reg[25:0], in_data.byte_in[5:0]} : lead_value(in_data.byte_in);
        flush    = !cont && pv_reg;
        first_pt = flush ? pp_reg : new_pt;
        units_a  = (|first_pt[31:16]) ? 2'd2 : 2'd1;
        units_b  = (|new_pt[31:16]) ? 2'd2 : 2'd1;

        pc_sum1 = {2'b00, pc_reg} + (CNT_W+2)'(1);
        pc_sum2 = {2'b00, pc_reg} + (CNT_W+2)'(2);
        uc_sum1 = {2'b00, uc_reg} + {{CNT_W{1'b0}}, units_a};
        uc_sum2 = uc_sum1 + {{CNT_W{1'b0}}, units_b};
        pc1 = sat_cnt(pc_sum1);
        pc2 = sat_cnt(pc_sum2);
        uc1 = sat_cnt(uc_sum1);
        uc2 = sat_cnt(uc_sum2);

        push.cnt = fire ? ({1'b0, flush} + {1'b0, in_data.string_end}) : 2'd0;

        push.first.code_point    = first_pt;
        push.first.utf16_units   = units_a;
        push.first.points_so_far = pc1;
        push.first.units_so_far  = uc1;
        push.first.last_point    = !flush;

        push.second.code_point    = new_pt;
        push.second.utf16_units   = units_b;
        push.second.points_so_far = pc2;
        push.second.units_so_far  = uc2;
        push.second.last_point    = 1'b1;

        pv_next = pv_reg;
        pp_next = pp_reg;
        pc_next = pc_reg;
        uc_next = uc_reg;
        if (fire) begin
            if (in_data.string_end) begin
                pv_next = 1'b0;
                pp_next = 32'd0;
                pc_next = '0;
                uc_next = '0;
            end else begin
                pv_next = 1'b1;
                pp_next = new_pt;
                pc_next = flush ? pc1 : pc_reg;
                uc_next = flush ? uc1 : uc_reg;
            end
        end
    end

    assign pend_busy = pv_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pv_reg <= 1'b0;
            pp_reg <= 32'd0;
            pc_reg <= '0;
            uc_reg <= '0;
        end else begin
            pv_reg <= pv_next;
            pp_reg <= pp_next;
            pc_reg <= pc_next;
            uc_reg <= uc_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/utf8d_result_queue.sv
// ----------------------------------------------------------------------------
// UTF-8 decoder result queue
// Small register queue taking up to two results per cycle and handing one
// result per cycle to the output channel while it is popped.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8d_result_queue import utf8d_pkg::*; (
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire push_t push,
    input  wire logic  pop,
    output out_t       head,
    output logic       not_empty,
    output logic       room_two
);

    out_t             mem [RQ_DEPTH];
    logic [RQ_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [RQ_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [RQ_CW-1:0] count_reg, count_next;
    logic [RQ_AW-1:0] wr_ptr_plus1;

    always_comb begin
        wr_ptr_plus1 = wr_ptr_reg + RQ_AW'(1);
        wr_ptr_next  = wr_ptr_reg + RQ_AW'(push.cnt);
        rd_ptr_next  = pop ? (rd_ptr_reg + RQ_AW'(1)) : rd_ptr_reg;
        count_next   = count_reg + RQ_CW'(push.cnt) - RQ_CW'(pop);
    end

    assign head      = mem[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign room_two  = (count_reg <= RQ_CW'(RQ_DEPTH - 2));

    always_ff @(posedge aclk) begin
        if (push.cnt != 2'd0) begin
            mem[wr_ptr_reg] <= push.first;
        end
        if (push.cnt == 2'd2) begin
            mem[wr_ptr_plus1] <= push.second;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

>>> sim/utf8_to_utf32_decoder_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// UTF-8 to UTF-32 decoder core testbench
// Feeds byte strings through the decoder and compares every decoded code point
// and its running totals with a cycle-free predictor or table. A directed table
// covers the lead masks, stray continuations, flushes and wrapping; random
// strings of mostly well-formed sequences follow, under random idling on both
// sides and one long result stall that backs up the request side.
// ----------------------------------------------------------------------------

module utf8_to_utf32_decoder_core_test;
    import utf8d_pkg::*;

    localparam int CLK_PERIOD     = 8;
    localparam int RAND_PER_PHASE = 400;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 8;
    localparam int TIMEOUT_NS     = 2_000_000;
    localparam int DIR_N          = 26;

    typedef struct packed {
        in_t        req;
        logic       typed;
        logic [1:0] cnt;
        out_t       r0;
        out_t       r1;
    } dir_row_t;

    localparam out_t NONE = '0;

    localparam dir_row_t DIR_TBL [DIR_N] = '{
        '{'{8'h00, 1'b1}, 1'b1, 2'd1, '{32'h0000_0000, 2'd1, 24'd1, 24'd1, 1'b1}, NONE},
        '{'{8'h7F, 1'b1}, 1'b1, 2'd1, '{32'h0000_007F, 2'd1, 24'd1, 24'd1, 1'b1}, NONE},
        '{'{8'hFF, 1'b1}, 1'b1, 2'd1, '{32'h0000_0000, 2'd1, 24'd1, 24'd1, 1'b1}, NONE},
        '{'{8'hFE, 1'b1}, 1'b1, 2'd1, '{32'h0000_0000, 2'd1, 24'd1, 24'd1, 1'b1}, NONE},
        '{'{8'h80, 1'b1}, 1'b1, 2'd1, '{32'h0000_0000, 2'd1, 24'd1, 24'd1, 1'b1}, NONE},
        '{'{8'hBF, 1'b1}, 1'b1, 2'd1, '{32'h0000_003F, 2'd1, 24'd1, 24'd1, 1'b1}, NONE},
        '{'{8'hC3, 1'b0}, 1'b1, 2'd0, NONE, NONE},
        '{'{8'hA9, 1'b1}, 1'b1, 2'd1, '{32'h0000_00E9, 2'd1, 24'd1, 24'd1, 1'b1}, NONE},
        '{'{8'hF0, 1'b0}, 1'b1, 2'd0, NONE, NONE},
        '{'{8'h9F, 1'b0}, 1'b1, 2'd0, NONE, NONE},
        '{'{8'h98, 1'b0}, 1'b1, 2'd0, NONE, NONE},
        '{'{8'h80, 1'b1}, 1'b1, 2'd1, '{32'h0001_F600, 2'd2, 24'd1, 24'd2, 1'b1}, NONE},
        '{'{8'h41, 1'b0}, 1'b1, 2'd0, NONE, NONE},
        '{'{8'h42, 1'b1}, 1'b1, 2'd2, '{32'h0000_0041, 2'd1, 24'd1, 24'd1, 1'b0},
                                      '{32'h0000_0042, 2'd1, 24'd2, 24'd2, 1'b1}},
        '{'{8'hBF, 1'b0}, 1'b1, 2'd0, NONE, NONE},
        '{'{8'hBF, 1'b0}, 1'b1, 2'd0, NONE, NONE},
        '{'{8'h7F, 1'b1}, 1'b1, 2'd2, '{32'h0000_0FFF, 2'd1, 24'd1, 24'd1, 1'b0},
                                      '{32'h0000_007F, 2'd1, 24'd2, 24'd2, 1'b1}},
        '{'{8'hFD, 1'b0}, 1'b0, 2'd0, NONE, NONE},
        '{'{8'hBF, 1'b0}, 1'b0, 2'd0, NONE, NONE},
        '{'{8'hBF, 1'b0}, 1'b0, 2'd0, NONE, NONE},
        '{'{8'hBF, 1'b0}, 1'b0, 2'd0, NONE, NONE},
        '{'{8'hBF, 1'b0}, 1'b0, 2'd0, NONE, NONE},
        '{'{8'hBF, 1'b0}, 1'b0, 2'd0, NONE, NONE},
        '{'{8'hBF, 1'b1}, 1'b0, 2'd0, NONE, NONE},
        '{'{8'hF8, 1'b0}, 1'b0, 2'd0, NONE, NONE},
        '{'{8'hF7, 1'b1}, 1'b0, 2'd0, NONE, NONE}
    };

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_t  s_data  = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_t m_data;

    // predictor state
    logic             building    = 1'b0;
    logic [31:0]      build_point = '0;
    logic [CNT_W-1:0] seen_points = '0;
    logic [CNT_W-1:0] seen_units  = '0;

    out_t step_res   [$];
    out_t points_due [$];

    int   err_cnt       = 0;
    int   items_sent    = 0;
    int   send_idle_pct = 21;
    int   recv_idle_pct = 53;
    logic hold_req      = 1'b0;
    logic hold_taken    = 1'b0;
    int   hold_left     = 0;

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    utf8_to_utf32_decoder_core u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    function automatic logic [31:0] lead_bits(input logic [7:0] b);
        int         ones;
        logic [7:0] keep;
        ones = 0;
        while (ones < 8 && b[7 - ones]) ones++;
        keep = 8'hFF >> (ones + 1);
        return {24'd0, b & keep};
    endfunction

    function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                                 input logic [1:0] d);
        logic [CNT_W:0] s;
        s = a + d;
        return s[CNT_W] ? CNT_MAX : s[CNT_W-1:0];
    endfunction

    function automatic out_t count_point(input logic [31:0] cp, input logic last);
        out_t r;
        r.code_point    = cp;
        r.utf16_units   = (cp > 32'h0000_FFFF) ? 2'd2 : 2'd1;
        seen_points     = sat_add(seen_points, 2'd1);
        seen_units      = sat_add(seen_units, r.utf16_units);
        r.points_so_far = seen_points;
        r.units_so_far  = seen_units;
        r.last_point    = last;
        return r;
    endfunction

    task automatic decode_byte(input in_t req);
        step_res.delete();
        if (req.byte_in[7:6] == 2'b10 && building) begin
            build_point = {build_point[25:0], req.byte_in[5:0]};
        end else begin
            if (building) step_res.push_back(count_point(build_point, 1'b0));
            build_point = lead_bits(req.byte_in);
            building    = 1'b1;
        end
        if (req.string_end) begin
            step_res.push_back(count_point(build_point, 1'b1));
            building    = 1'b0;
            build_point = '0;
            seen_points = '0;
            seen_units  = '0;
        end
    endtask

    task automatic send(input in_t req, input logic typed, input logic [1:0] cnt,
                        input out_t r0, input out_t r1);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        do @(posedge aclk); while (!s_ready);
        decode_byte(req);
        if (typed) begin
            if (cnt > 0) points_due.push_back(r0);
            if (cnt > 1) points_due.push_back(r1);
        end else begin
            foreach (step_res[k]) points_due.push_back(step_res[k]);
        end
        items_sent++;
    endtask

    // mostly well-formed sequences; some noise bytes and truncated or overlong runs
    task automatic send_string();
        logic [7:0] str [$];
        logic [7:0] prefix;
        int         target;
        int         kind;
        int         n;
        int         ncont;
        target = ($urandom_range(19) == 0) ? $urandom_range(60, 150) : $urandom_range(1, 12);
        while (str.size() < target) begin
            kind = $urandom_range(99);
            if (kind < 10) begin
                str.push_back(8'($urandom_range(255)));
            end else begin
                n = (kind < 40) ? 1 : (kind < 60) ? 2 : (kind < 75) ? 3 :
                    (kind < 90) ? 4 : $urandom_range(5, 6);
                if (n == 1) begin
                    str.push_back(8'($urandom_range(127)));
                end else begin
                    prefix = 8'hFF << (8 - n);
                    str.push_back(prefix | (8'($urandom) & (8'hFF >> (n + 1))));
                end
                ncont = ($urandom_range(9) == 0) ? $urandom_range(0, 6) : n - 1;
                repeat (ncont) str.push_back(8'h80 | 8'($urandom_range(63)));
            end
        end
        foreach (str[k]) send('{str[k], k == str.size() - 1}, 1'b0, 2'd0, NONE, NONE);
    endtask

    task automatic check_point(input out_t got);
        out_t want;
        if (points_due.size() == 0) begin
            $error("unexpected result: code_point %h", got.code_point);
            err_cnt++;
        end else begin
            want = points_due.pop_front();
            if (got.code_point !== want.code_point) begin
                $error("code_point: expected %h, got %h", want.code_point, got.code_point);
                err_cnt++;
            end
            if (got.utf16_units !== want.utf16_units) begin
                $error("utf16_units: expected %0d, got %0d", want.utf16_units, got.utf16_units);
                err_cnt++;
            end
            if (got.points_so_far !== want.points_so_far) begin
                $error("points_so_far: expected %0d, got %0d",
                       want.points_so_far, got.points_so_far);
                err_cnt++;
            end
            if (got.units_so_far !== want.units_so_far) begin
                $error("units_so_far: expected %0d, got %0d",
                       want.units_so_far, got.units_so_far);
                err_cnt++;
            end
            if (got.last_point !== want.last_point) begin
                $error("last_point: expected %0d, got %0d", want.last_point, got.last_point);
                err_cnt++;
            end
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) check_point(m_data);
        if (hold_req && !hold_taken) begin
            hold_taken <= 1'b1;
            hold_left  <= HOLD_CYCLES;
            m_ready    <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial begin
        int mark;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        for (int i = 0; i < DIR_N; i++) begin
            send(DIR_TBL[i].req, DIR_TBL[i].typed, DIR_TBL[i].cnt, DIR_TBL[i].r0,
                 DIR_TBL[i].r1);
        end

        mark = items_sent;
        while (items_sent - mark < RAND_PER_PHASE) send_string();

        send_idle_pct <= 53;
        recv_idle_pct <= 21;
        mark = items_sent;
        while (items_sent - mark < RAND_PER_PHASE) send_string();

        // no idling; stall the result side once so the request side backs up
        send_idle_pct <= 0;
        recv_idle_pct <= 0;
        hold_req      <= 1'b1;
        mark = items_sent;
        while (items_sent - mark < RAND_PER_PHASE) send_string();
        s_valid <= 1'b0;

        while (points_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (err_cnt == 0) begin
            $display("utf8_to_utf32_decoder_core_test: PASS");
        end else begin
            $display("utf8_to_utf32_decoder_core_test: FAIL");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("utf8_to_utf32_decoder_core_test: FAIL");
        $finish;
    end

endmodule

>>> utf8_to_utf32_decoder_core.f
+incdir+rtl
rtl/utf8d_pkg.sv
rtl/utf8d_step.sv
rtl/utf8d_result_queue.sv
rtl/utf8_to_utf32_decoder_core.sv
sim/utf8_to_utf32_decoder_core_test.sv
